// ===== hdl/eacc_pkg.sv =====
// ----------------------------------------------------------------------------
// eacc_pkg
// Shared types and constants for the charger energy meter: field types,
// operation codes, register indexes, accumulator lane numbering and the
// digit width of the serial datapath.
// ----------------------------------------------------------------------------
package eacc_pkg;

    // field types
    typedef logic [63:0] energy_t;
    typedef logic [39:0] elapsed_t;
    typedef logic [31:0] ms_t;
    typedef logic [31:0] count_t;
    typedef logic [2:0]  op_t;
    typedef logic [13:0] volt_t;
    typedef logic [16:0] amps_t;
    typedef logic [2:0]  weekday_t;
    typedef logic [3:0]  month_t;
    typedef logic [15:0] year_t;
    typedef logic [0:0]  cfg_index_t;
    typedef logic [31:0] cfg_data_t;

    // operation codes
    localparam op_t OP_UPDATE        = 3'd0;
    localparam op_t OP_CLEAR_SESSION = 3'd1;
    localparam op_t OP_IMPORT        = 3'd2;
    localparam op_t OP_RESET_PERIODS = 3'd3;
    localparam op_t OP_FULL_RESET    = 3'd4;

    // configuration register indexes
    localparam cfg_index_t REG_THREE_PHASE     = 1'd0;
    localparam cfg_index_t REG_ROTATE_INTERVAL = 1'd1;

    localparam ms_t ROTATE_INTERVAL_RST = 32'd60000;
    localparam weekday_t SUNDAY         = 3'd0;

    // energy accumulator lanes
    localparam int NUM_LANES    = 6;
    localparam int LANE_SESSION = 0;
    localparam int LANE_TOTAL   = 1;
    localparam int LANE_DAY     = 2;
    localparam int LANE_WEEK    = 3;
    localparam int LANE_MONTH   = 4;
    localparam int LANE_YEAR    = 5;

    // serial datapath: one 8-bit digit per cycle
    localparam int DIGIT_W    = 8;
    localparam int MUL_DIGITS = 32 / DIGIT_W;
    localparam int ACC_DIGITS = 64 / DIGIT_W;
    localparam int EL_DIGITS  = 40 / DIGIT_W;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [2:0]         digit_cnt_t;

endpackage

// ===== hdl/energy_period_accumulator.sv =====
// ----------------------------------------------------------------------------
// energy_period_accumulator
// Charger energy meter: accumulates V*I*dt into six saturating period
// accumulators, tracks charging time, switch events and calendar rollover.
// A charging update runs V*I, three-phase scaling, the 8-bit digit-serial
// multiply by dt (4 digits) and the accumulator pass (8 digits); imports run
// only the accumulator pass, other transactions only the result load. in_stall
// holds new transactions until the last result is loaded. Reset (rst_n low)
// clears all accumulators and timing state; rotate interval returns to 60000 ms.
// ----------------------------------------------------------------------------
module energy_period_accumulator (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_write,
    input  eacc_pkg::cfg_index_t   cfg_index,
    input  eacc_pkg::cfg_data_t    cfg_data,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  eacc_pkg::op_t          operation,
    input  eacc_pkg::ms_t          time_ms,
    input  logic                   charging,
    input  logic                   active,
    input  eacc_pkg::volt_t        voltage_dv,
    input  eacc_pkg::amps_t        current_ma,
    input  eacc_pkg::weekday_t     weekday,
    input  eacc_pkg::month_t       month,
    input  eacc_pkg::year_t        year,
    input  eacc_pkg::energy_t      import_energy,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output eacc_pkg::energy_t      sess_energy,
    output eacc_pkg::energy_t      lifetime_energy,
    output eacc_pkg::energy_t      day_energy,
    output eacc_pkg::energy_t      week_energy,
    output eacc_pkg::energy_t      month_energy,
    output eacc_pkg::energy_t      year_energy,
    output eacc_pkg::elapsed_t     elapsed_ms,
    output eacc_pkg::count_t       switch_count,
    output logic                   rotated,
    output logic                   imported
);

    import eacc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_VA   = 3'd1;
    localparam logic [2:0] ST_M3   = 3'd2;
    localparam logic [2:0] ST_DIG  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    // control
    logic [2:0]     state_reg, state_next;
    digit_cnt_t     cnt_reg, cnt_next;
    logic           out_valid_reg, out_valid_next;

    // configuration
    logic           three_phase_reg, three_phase_next;
    ms_t            interval_reg, interval_next;

    // architectural state
    energy_t        acc_reg [NUM_LANES];
    energy_t        acc_next [NUM_LANES];
    elapsed_t       el_reg, el_next;
    count_t         switch_reg, switch_next;
    weekday_t       st_wd_reg, st_wd_next;
    month_t         st_mo_reg, st_mo_next;
    year_t          st_yr_reg, st_yr_next;
    logic           imported_reg, imported_next;
    ms_t            last_time_reg, last_time_next;
    logic           started_reg, started_next;
    ms_t            last_rot_reg, last_rot_next;
    logic           last_active_reg, last_active_next;

    // latched transaction fields
    op_t            op_reg, op_next;
    ms_t            now_reg, now_next;
    logic           act_reg, act_next;
    volt_t          volt_reg, volt_next;
    amps_t          amps_reg, amps_next;
    weekday_t       wd_reg, wd_next;
    month_t         mo_reg, mo_next;
    year_t          yr_reg, yr_next;

    // serial datapath
    logic [30:0]    va_reg, va_next;
    logic [32:0]    m_reg, m_next;
    ms_t            mdt_reg, mdt_next;
    ms_t            edt_reg, edt_next;
    logic [33:0]    mcarry_reg, mcarry_next;
    energy_t        add_reg, add_next;
    logic [NUM_LANES-1:0] lane_en_reg, lane_en_next;
    logic           el_en_reg, el_en_next;
    logic [NUM_LANES-1:0] carry_reg, carry_next;
    logic           el_carry_reg, el_carry_next;

    // output register
    energy_t        o_acc_reg [NUM_LANES];
    energy_t        o_acc_next [NUM_LANES];
    elapsed_t       o_el_reg, o_el_next;
    count_t         o_switch_reg, o_switch_next;
    logic           o_rot_reg, o_rot_next;
    logic           o_imp_reg, o_imp_next;

    // combinational temporaries
    ms_t            dt;
    logic [41:0]    mul_sum;
    logic [8:0]     lane_sum;
    logic [8:0]     el_sum;
    logic           cin;
    ms_t            rot_diff;
    logic           wd_chg;
    logic           mo_chg;
    logic           yr_chg;
    logic           rot_flag;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign sess_energy     = o_acc_reg[LANE_SESSION];
    assign lifetime_energy = o_acc_reg[LANE_TOTAL];
    assign day_energy      = o_acc_reg[LANE_DAY];
    assign week_energy     = o_acc_reg[LANE_WEEK];
    assign month_energy    = o_acc_reg[LANE_MONTH];
    assign year_energy     = o_acc_reg[LANE_YEAR];
    assign elapsed_ms      = o_el_reg;
    assign switch_count    = o_switch_reg;
    assign rotated         = o_rot_reg;
    assign imported        = o_imp_reg;

    // next-state logic
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        three_phase_next = three_phase_reg;
        interval_next    = interval_reg;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            acc_next[i]   = acc_reg[i];
            o_acc_next[i] = o_acc_reg[i];
        end
        el_next          = el_reg;
        switch_next      = switch_reg;
        st_wd_next       = st_wd_reg;
        st_mo_next       = st_mo_reg;
        st_yr_next       = st_yr_reg;
        imported_next    = imported_reg;
        last_time_next   = last_time_reg;
        started_next     = started_reg;
        last_rot_next    = last_rot_reg;
        last_active_next = last_active_reg;
        op_next          = op_reg;
        now_next         = now_reg;
        act_next         = act_reg;
        volt_next        = volt_reg;
        amps_next        = amps_reg;
        wd_next          = wd_reg;
        mo_next          = mo_reg;
        yr_next          = yr_reg;
        va_next          = va_reg;
        m_next           = m_reg;
        mdt_next         = mdt_reg;
        edt_next         = edt_reg;
        mcarry_next      = mcarry_reg;
        add_next         = add_reg;
        lane_en_next     = lane_en_reg;
        el_en_next       = el_en_reg;
        carry_next       = carry_reg;
        el_carry_next    = el_carry_reg;
        o_el_next        = o_el_reg;
        o_switch_next    = o_switch_reg;
        o_rot_next       = o_rot_reg;
        o_imp_next       = o_imp_reg;

        dt       = time_ms - last_time_reg;
        mul_sum  = '0;
        lane_sum = '0;
        el_sum   = '0;
        cin      = 1'b0;
        rot_diff = now_reg - last_rot_reg;
        wd_chg   = 1'b0;
        mo_chg   = 1'b0;
        yr_chg   = 1'b0;
        rot_flag = 1'b0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_THREE_PHASE:     three_phase_next = cfg_data[0];
                REG_ROTATE_INTERVAL: interval_next    = cfg_data;
                default:             ;
            endcase
        end

        case (state_reg)
            // take a transaction and pick its path
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = operation;
                    now_next  = time_ms;
                    act_next  = active;
                    volt_next = voltage_dv;
                    amps_next = current_ma;
                    wd_next   = weekday;
                    mo_next   = month;
                    yr_next   = year;
                    mdt_next  = dt;
                    edt_next  = dt;
                    cnt_next  = '0;
                    if (operation == OP_UPDATE && started_reg && charging)
                    begin
                        lane_en_next = '1;
                        el_en_next   = 1'b1;
                        state_next   = ST_VA;
                    end
                    else if (operation == OP_IMPORT)
                    begin
                        add_next                 = import_energy;
                        lane_en_next             = '0;
                        lane_en_next[LANE_TOTAL] = 1'b1;
                        el_en_next               = 1'b0;
                        state_next               = ST_ACC;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            // power term V*I
            ST_VA:
            begin
                va_next    = {17'd0, volt_reg} * {14'd0, amps_reg};
                state_next = ST_M3;
            end

            // three-phase scaling of the multiplicand
            ST_M3:
            begin
                if (three_phase_reg)
                    m_next = {2'b00, va_reg} + {1'b0, va_reg, 1'b0};
                else
                    m_next = {2'b00, va_reg};
                state_next = ST_DIG;
            end

            // digit-serial multiply by dt, LSB digit first
            ST_DIG:
            begin
                mul_sum = ({9'd0, m_reg} * {34'd0, mdt_reg[DIGIT_W-1:0]})
                        + {8'd0, (cnt_reg == '0) ? 34'd0 : mcarry_reg};
                mcarry_next = mul_sum[41:8];
                mdt_next    = {{DIGIT_W{1'b0}}, mdt_reg[31:DIGIT_W]};
                add_next    = {mul_sum[DIGIT_W-1:0], add_reg[63:DIGIT_W]};
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == 3'(MUL_DIGITS - 1))
                begin
                    // increment saturates if the product spills past 64 bits
                    if (mul_sum[41:40] != 2'b00)
                        add_next = '1;
                    else
                        add_next = {mul_sum[39:8], mul_sum[DIGIT_W-1:0],
                                    add_reg[63:40]};
                    cnt_next   = '0;
                    state_next = ST_ACC;
                end
            end

            // digit-serial saturating adds on every enabled lane
            ST_ACC:
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    cin      = (cnt_reg == '0) ? 1'b0 : carry_reg[i];
                    lane_sum = {1'b0, acc_reg[i][DIGIT_W-1:0]}
                             + {1'b0, add_reg[DIGIT_W-1:0]} + {8'd0, cin};
                    carry_next[i] = lane_sum[8];
                    if (lane_en_reg[i])
                    begin
                        if (cnt_reg == 3'(ACC_DIGITS - 1) && lane_sum[8])
                            acc_next[i] = '1;
                        else
                            acc_next[i] = {lane_sum[DIGIT_W-1:0],
                                           acc_reg[i][63:DIGIT_W]};
                    end
                end
                // elapsed time rides along over its five digits
                cin    = (cnt_reg == '0) ? 1'b0 : el_carry_reg;
                el_sum = {1'b0, el_reg[DIGIT_W-1:0]}
                       + {1'b0, edt_reg[DIGIT_W-1:0]} + {8'd0, cin};
                el_carry_next = el_sum[8];
                if (el_en_reg && cnt_reg < 3'(EL_DIGITS))
                begin
                    if (cnt_reg == 3'(EL_DIGITS - 1) && el_sum[8])
                        el_next = '1;
                    else
                        el_next = {el_sum[DIGIT_W-1:0], el_reg[39:DIGIT_W]};
                end
                edt_next = {{DIGIT_W{1'b0}}, edt_reg[31:DIGIT_W]};
                add_next = {{DIGIT_W{1'b0}}, add_reg[63:DIGIT_W]};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(ACC_DIGITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end

            // bookkeeping, calendar check and result load
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    case (op_reg)
                        OP_UPDATE:
                        begin
                            if (act_reg != last_active_reg)
                                switch_next = switch_reg + 32'd1;
                            last_active_next = act_reg;
                            last_time_next   = now_reg;
                            if (!started_reg)
                            begin
                                started_next = 1'b1;
                            end
                            else if (rot_diff >= interval_reg)
                            begin
                                last_rot_next = now_reg;
                                wd_chg = (st_wd_reg != wd_reg);
                                mo_chg = (st_mo_reg != mo_reg);
                                yr_chg = (st_yr_reg != yr_reg);
                                if (wd_chg)
                                begin
                                    acc_next[LANE_DAY] = '0;
                                    if (wd_reg == SUNDAY)
                                        acc_next[LANE_WEEK] = '0;
                                    st_wd_next = wd_reg;
                                end
                                if (mo_chg)
                                begin
                                    acc_next[LANE_MONTH] = '0;
                                    st_mo_next = mo_reg;
                                end
                                if (yr_chg)
                                begin
                                    acc_next[LANE_YEAR] = '0;
                                    st_yr_next = yr_reg;
                                end
                                rot_flag = wd_chg || mo_chg || yr_chg;
                            end
                        end
                        OP_CLEAR_SESSION:
                        begin
                            acc_next[LANE_SESSION] = '0;
                            el_next = '0;
                        end
                        OP_IMPORT:
                        begin
                            imported_next = 1'b1;
                        end
                        OP_RESET_PERIODS, OP_FULL_RESET:
                        begin
                            for (int i = 0; i < NUM_LANES; i++)
                            begin
                                if (i != LANE_TOTAL)
                                    acc_next[i] = '0;
                            end
                            el_next    = '0;
                            st_wd_next = wd_reg;
                            st_mo_next = mo_reg;
                            st_yr_next = yr_reg;
                            if (op_reg == OP_FULL_RESET)
                            begin
                                acc_next[LANE_TOTAL] = '0;
                                switch_next = '0;
                            end
                        end
                        default: ;
                    endcase

                    for (int i = 0; i < NUM_LANES; i++)
                    begin
                        o_acc_next[i] = acc_next[i];
                    end
                    o_el_next      = el_next;
                    o_switch_next  = switch_next;
                    o_rot_next     = rot_flag;
                    o_imp_next     = imported_next;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            three_phase_reg <= 1'b0;
            interval_reg    <= ROTATE_INTERVAL_RST;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                acc_reg[i] <= '0;
            end
            el_reg          <= '0;
            switch_reg      <= '0;
            st_wd_reg       <= '0;
            st_mo_reg       <= '0;
            st_yr_reg       <= '0;
            imported_reg    <= 1'b0;
            last_time_reg   <= '0;
            started_reg     <= 1'b0;
            last_rot_reg    <= '0;
            last_active_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            three_phase_reg <= three_phase_next;
            interval_reg    <= interval_next;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
            el_reg          <= el_next;
            switch_reg      <= switch_next;
            st_wd_reg       <= st_wd_next;
            st_mo_reg       <= st_mo_next;
            st_yr_reg       <= st_yr_next;
            imported_reg    <= imported_next;
            last_time_reg   <= last_time_next;
            started_reg     <= started_next;
            last_rot_reg    <= last_rot_next;
            last_active_reg <= last_active_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        act_reg       <= act_next;
        volt_reg      <= volt_next;
        amps_reg      <= amps_next;
        wd_reg        <= wd_next;
        mo_reg        <= mo_next;
        yr_reg        <= yr_next;
        va_reg        <= va_next;
        m_reg         <= m_next;
        mdt_reg       <= mdt_next;
        edt_reg       <= edt_next;
        mcarry_reg    <= mcarry_next;
        add_reg       <= add_next;
        lane_en_reg   <= lane_en_next;
        el_en_reg     <= el_en_next;
        carry_reg     <= carry_next;
        el_carry_reg  <= el_carry_next;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            o_acc_reg[i] <= o_acc_next[i];
        end
        o_el_reg      <= o_el_next;
        o_switch_reg  <= o_switch_next;
        o_rot_reg     <= o_rot_next;
        o_imp_reg     <= o_imp_next;
    end

endmodule
